// File: src/v2dfp_pkg.sv
// Shared types, constants and helper functions for the 2-D fixed-point vector unit.
package v2dfp_pkg;

	typedef enum logic [3:0] {
		OP_ADD       = 4'd0,
		OP_SUB       = 4'd1,
		OP_SCALE     = 4'd2,
		OP_DIVIDE    = 4'd3,
		OP_NEGATE    = 4'd4,
		OP_ROTATE    = 4'd5,
		OP_NORMALIZE = 4'd6,
		OP_QUADRANT  = 4'd7,
		OP_MAGNITUDE = 4'd8,
		OP_ANGLE     = 4'd9,
		OP_DOT       = 4'd10
	} op_t;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_DIVZ = 2'd1;
	localparam logic [1:0] ST_SAT  = 2'd2;

	localparam logic [1:0] Q_NE = 2'd0;
	localparam logic [1:0] Q_NW = 2'd1;
	localparam logic [1:0] Q_SW = 2'd2;
	localparam logic [1:0] Q_SE = 2'd3;

	localparam int GUARD = 8;     // extra fraction bits inside CORDIC
	localparam int PS_SH = 30 - GUARD;
	localparam int XW    = 42;    // CORDIC x/y width
	localparam int AW    = 44;    // angle width, 30 fraction bits
	localparam int DW    = 34;    // divisor magnitude width
	localparam int SATW  = 72;    // headroom for pre-saturation values

	localparam logic signed [31:0]   KINV_Q30   = 32'sd652032874;
	localparam logic signed [AW-1:0] PI_Q30     = 44'sd3373259426;
	localparam logic signed [AW-1:0] HALFPI_Q30 = 44'sd1686629713;
	localparam logic signed [AW-1:0] TWOPI_Q30  = 44'sd6746518852;
	localparam logic signed [63:0]   PS_HALF    = 64'sd1 <<< (PS_SH - 1);
	localparam logic signed [SATW-1:0] HALF_G   = SATW'(1) <<< (GUARD - 1);
	localparam logic signed [SATW-1:0] S_MAX    = SATW'(32'sh7fff_ffff);
	localparam logic signed [SATW-1:0] S_MIN    = SATW'(32'sh8000_0000);

	typedef struct packed {
		logic signed [31:0] v;
		logic               ov;
	} sat_t;

	// per-item side data that rides along the whole pipeline
	typedef struct packed {
		op_t                op;
		logic signed [31:0] px;
		logic signed [31:0] py;
		logic signed [31:0] f;
		logic signed [31:0] rx;
		logic signed [31:0] ry;
		logic signed [31:0] rs;
		logic [1:0]         rq;
		logic               ovf;
		logic               dz;
		logic               vz;
		logic               negx;
		logic               negy;
	} ctx_t;

	function automatic sat_t sat32(input logic signed [SATW-1:0] v);
		sat_t r;
		r.ov = 1'b0;
		r.v  = v[31:0];
		if (v > S_MAX) begin
			r.ov = 1'b1;
			r.v  = S_MAX[31:0];
		end else if (v < S_MIN) begin
			r.ov = 1'b1;
			r.v  = S_MIN[31:0];
		end
		return r;
	endfunction

	function automatic logic [1:0] quad(input logic signed [31:0] x, input logic signed [31:0] y);
		logic [1:0] q;
		q = Q_NE;
		if (x > 0 && y >= 0) q = Q_NE;
		else if (x <= 0 && y > 0) q = Q_NW;
		else if (x < 0 && y <= 0) q = Q_SW;
		else if (x >= 0 && y < 0) q = Q_SE;
		return q;
	endfunction

	// arctan(2^-i) with 30 fraction bits
	function automatic logic [29:0] atan_q30(input int i);
		logic [29:0] r;
		case (i)
			0:  r = 30'd843314857;
			1:  r = 30'd497837829;
			2:  r = 30'd263043837;
			3:  r = 30'd133525159;
			4:  r = 30'd67021687;
			5:  r = 30'd33543516;
			6:  r = 30'd16775851;
			7:  r = 30'd8388437;
			8:  r = 30'd4194283;
			9:  r = 30'd2097149;
			10: r = 30'd1048576;
			11: r = 30'd524288;
			12: r = 30'd262144;
			13: r = 30'd131072;
			14: r = 30'd65536;
			15: r = 30'd32768;
			16: r = 30'd16384;
			17: r = 30'd8192;
			18: r = 30'd4096;
			19: r = 30'd2048;
			20: r = 30'd1024;
			21: r = 30'd512;
			22: r = 30'd256;
			23: r = 30'd128;
			24: r = 30'd64;
			25: r = 30'd32;
			26: r = 30'd16;
			27: r = 30'd8;
			28: r = 30'd4;
			29: r = 30'd2;
			30: r = 30'd1;
			default: r = 30'd0;
		endcase
		return r;
	endfunction

endpackage

// File: src/v2dfp_cordic_cell.sv
// One CORDIC micro-rotation cell, rotation or vectoring mode per item.
module v2dfp_cordic_cell #(
	parameter int SHIFT = 0
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           en,
	input  logic                           v_in,
	input  v2dfp_pkg::ctx_t                ctx_in,
	input  logic signed [v2dfp_pkg::XW-1:0] x_in,
	input  logic signed [v2dfp_pkg::XW-1:0] y_in,
	input  logic signed [v2dfp_pkg::AW-1:0] z_in,
	output logic                           v_q,
	output v2dfp_pkg::ctx_t                ctx_q,
	output logic signed [v2dfp_pkg::XW-1:0] x_q,
	output logic signed [v2dfp_pkg::XW-1:0] y_q,
	output logic signed [v2dfp_pkg::AW-1:0] z_q
);
	import v2dfp_pkg::*;

	localparam logic signed [AW-1:0] ATAN = AW'(atan_q30(SHIFT));

	logic              rot;
	logic              pos;
	logic signed [XW-1:0] xs, ys, xn, yn;
	logic signed [AW-1:0] zn;

	always_comb begin
		rot = (ctx_in.op == OP_ROTATE);
		// rotation turns by sign of z; vectoring drives y toward zero
		pos = rot ? !z_in[AW-1] : (y_in <= 0);
		xs  = x_in >>> SHIFT;
		ys  = y_in >>> SHIFT;
		if (pos) begin
			xn = x_in - ys;
			yn = y_in + xs;
			zn = z_in - ATAN;
		end else begin
			xn = x_in + ys;
			yn = y_in - xs;
			zn = z_in + ATAN;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (en) begin
			v_q <= v_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctx_q <= ctx_in;
			x_q   <= xn;
			y_q   <= yn;
			z_q   <= zn;
		end
	end

endmodule

// File: src/v2dfp_div_cell.sv
// One restoring-division cell: one quotient bit per lane per cycle while en is high, x and y lanes.
module v2dfp_div_cell #(
	parameter int QW = 48
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        v_in,
	input  v2dfp_pkg::ctx_t             ctx_in,
	input  logic [QW-1:0]               accx_in,
	input  logic [QW-1:0]               accy_in,
	input  logic [v2dfp_pkg::DW-1:0]    remx_in,
	input  logic [v2dfp_pkg::DW-1:0]    remy_in,
	input  logic [v2dfp_pkg::DW-1:0]    dv_in,
	output logic                        v_q,
	output v2dfp_pkg::ctx_t             ctx_q,
	output logic [QW-1:0]               accx_q,
	output logic [QW-1:0]               accy_q,
	output logic [v2dfp_pkg::DW-1:0]    remx_q,
	output logic [v2dfp_pkg::DW-1:0]    remy_q,
	output logic [v2dfp_pkg::DW-1:0]    dv_q
);
	import v2dfp_pkg::*;

	logic [DW:0]   tx, ty, dext;
	logic          gex, gey;
	logic [DW-1:0] rxn, ryn;

	// accumulator shifts dividend bits out the top and quotient bits in the bottom
	always_comb begin
		dext = {1'b0, dv_in};
		tx   = {remx_in, accx_in[QW-1]};
		ty   = {remy_in, accy_in[QW-1]};
		gex  = (tx >= dext);
		gey  = (ty >= dext);
		rxn  = gex ? DW'(tx - dext) : DW'(tx);
		ryn  = gey ? DW'(ty - dext) : DW'(ty);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (en) begin
			v_q <= v_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctx_q  <= ctx_in;
			accx_q <= {accx_in[QW-2:0], gex};
			accy_q <= {accy_in[QW-2:0], gey};
			remx_q <= rxn;
			remy_q <= ryn;
			dv_q   <= dv_in;
		end
	end

endmodule

// File: src/vector2d_fixed_point_unit_core.sv
// Top level of the 2-D fixed-point vector unit: front end, CORDIC chain, divider chain.
//
// channel | signals                                   | transfer when
// --------+-------------------------------------------+-------------------------
// in      | opcode px py qx qy factor turn_angle      | in_valid && in_ready
// out     | res_x res_y res_scalar res_quadrant status| out_valid && out_ready
//
// One item per cycle sustained while the output is accepted. The path runs through
// four front stages, the CORDIC cell row, one post stage, 32 + FRAC_BITS divider
// cells and the output register. Reset clears only the valid bits.
// A result held at the output stalls the whole row; the input stage still takes
// one item while it is empty.
module vector2d_fixed_point_unit_core #(
	parameter int CORDIC_STEPS = 20,
	parameter int FRAC_BITS    = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [3:0]         opcode,
	input  logic signed [31:0] px,
	input  logic signed [31:0] py,
	input  logic signed [31:0] qx,
	input  logic signed [31:0] qy,
	input  logic signed [31:0] factor,
	input  logic signed [18:0] turn_angle,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] res_x,
	output logic signed [31:0] res_y,
	output logic signed [31:0] res_scalar,
	output logic [1:0]         res_quadrant,
	output logic [1:0]         status
);
	import v2dfp_pkg::*;

	localparam int QW  = 32 + FRAC_BITS;
	localparam int ASH = 30 - FRAC_BITS;
	localparam logic signed [SATW-1:0] HALF_F = SATW'(1) <<< (FRAC_BITS - 1);
	localparam logic signed [SATW-1:0] HALF_A = SATW'(1) <<< (ASH - 1);

	logic adv, ld1;

	// stage 1: input capture
	logic               v_s1;
	op_t                op_s1;
	logic signed [31:0] px_s1, py_s1, qx_s1, qy_s1, f_s1;
	logic signed [18:0] ta_s1;

	// stage 2: products, simple ops, angle wrap
	logic                 v_s2;
	ctx_t                 ctx_s2, ctx2;
	logic signed [63:0]   m1_s2, m2_s2, pkx_s2, pky_s2;
	logic signed [AW-1:0] a_s2, a0, a2;
	logic signed [31:0]   bx, by;
	sat_t                 s2x, s2y;

	// stage 3: rounding
	logic                 v_s3;
	ctx_t                 ctx_s3, ctx3;
	logic signed [XW-1:0] x0_s3, y0_s3;
	logic signed [AW-1:0] a_s3;
	sat_t                 s3x, s3y;

	// stage 4: CORDIC setup
	logic                 v_s4;
	ctx_t                 ctx_s4, ctx4;
	logic signed [XW-1:0] x_s4, y_s4, x4, y4;
	logic signed [AW-1:0] z_s4, z4;

	// CORDIC row
	logic                 cv   [CORDIC_STEPS+1];
	ctx_t                 cctx [CORDIC_STEPS+1];
	logic signed [XW-1:0] cx   [CORDIC_STEPS+1];
	logic signed [XW-1:0] cy   [CORDIC_STEPS+1];
	logic signed [AW-1:0] cz   [CORDIC_STEPS+1];

	// stage 5: post-CORDIC and divider setup
	logic                   v_s5;
	ctx_t                   ctx_s5, ctx5;
	logic [QW-1:0]          accx_s5, accy_s5;
	logic [DW-1:0]          dv_s5, dv5;
	logic signed [SATW-1:0] mg, ang;
	logic [DW-1:0]          mm;
	logic [31:0]            pxm, pym, fm;
	sat_t                   s5x, s5y;

	// divider row
	logic          dvv  [QW+1];
	ctx_t          dctx [QW+1];
	logic [QW-1:0] dax  [QW+1];
	logic [QW-1:0] day  [QW+1];
	logic [DW-1:0] drx  [QW+1];
	logic [DW-1:0] dry  [QW+1];
	logic [DW-1:0] ddv  [QW+1];

	// output register
	logic               out_valid_q;
	logic signed [31:0] res_x_q, res_y_q, res_scalar_q;
	logic [1:0]         res_quadrant_q, status_q;
	ctx_t               ctxf;
	logic signed [SATW-1:0] qvx, qvy;
	sat_t               sfx, sfy;
	logic signed [31:0] fx, fy;
	logic               fov;

	assign adv      = !out_valid_q || out_ready;
	assign ld1      = adv || !v_s1;
	assign in_ready = ld1;

	// ---------------- stage 1 ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (ld1) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ld1) begin
			op_s1 <= op_t'(opcode);
			px_s1 <= px;
			py_s1 <= py;
			qx_s1 <= qx;
			qy_s1 <= qy;
			f_s1  <= factor;
			ta_s1 <= turn_angle;
		end
	end

	// ---------------- stage 2 ----------------
	always_comb begin
		ctx2    = '0;
		ctx2.op = op_s1;
		ctx2.px = px_s1;
		ctx2.py = py_s1;
		ctx2.f  = f_s1;
		s2x     = '0;
		s2y     = '0;
		case (op_s1)
			OP_ADD: begin
				s2x = sat32(SATW'(px_s1) + SATW'(qx_s1));
				s2y = sat32(SATW'(py_s1) + SATW'(qy_s1));
			end
			OP_SUB: begin
				s2x = sat32(SATW'(px_s1) - SATW'(qx_s1));
				s2y = sat32(SATW'(py_s1) - SATW'(qy_s1));
			end
			OP_NEGATE: begin
				s2x = sat32(-SATW'(px_s1));
				s2y = sat32(-SATW'(py_s1));
			end
			OP_QUADRANT: ctx2.rq = quad(px_s1, py_s1);
			default: ;
		endcase
		ctx2.rx  = s2x.v;
		ctx2.ry  = s2y.v;
		ctx2.ovf = s2x.ov || s2y.ov;
		bx = (op_s1 == OP_DOT) ? qx_s1 : f_s1;
		by = (op_s1 == OP_DOT) ? qy_s1 : f_s1;
		a0 = AW'(ta_s1) <<< ASH;
		if (a0 > PI_Q30) a2 = a0 - TWOPI_Q30;
		else if (a0 < -PI_Q30) a2 = a0 + TWOPI_Q30;
		else a2 = a0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ctx_s2 <= ctx2;
			m1_s2  <= 64'(px_s1) * 64'(bx);
			m2_s2  <= 64'(py_s1) * 64'(by);
			pkx_s2 <= 64'(px_s1) * 64'(KINV_Q30);
			pky_s2 <= 64'(py_s1) * 64'(KINV_Q30);
			a_s2   <= a2;
		end
	end

	// ---------------- stage 3 ----------------
	always_comb begin
		ctx3 = ctx_s2;
		s3x  = '0;
		s3y  = '0;
		case (ctx_s2.op)
			OP_SCALE: begin
				s3x = sat32((SATW'(m1_s2) + HALF_F) >>> FRAC_BITS);
				s3y = sat32((SATW'(m2_s2) + HALF_F) >>> FRAC_BITS);
				ctx3.rx  = s3x.v;
				ctx3.ry  = s3y.v;
				ctx3.ovf = s3x.ov || s3y.ov;
			end
			OP_DOT: begin
				// exact sum of both products, rounded once
				s3x = sat32((SATW'(m1_s2) + SATW'(m2_s2) + HALF_F) >>> FRAC_BITS);
				ctx3.rs  = s3x.v;
				ctx3.ovf = s3x.ov;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ctx_s3 <= ctx3;
			x0_s3  <= XW'((pkx_s2 + PS_HALF) >>> PS_SH);
			y0_s3  <= XW'((pky_s2 + PS_HALF) >>> PS_SH);
			a_s3   <= a_s2;
		end
	end

	// ---------------- stage 4 ----------------
	always_comb begin
		ctx4    = ctx_s3;
		ctx4.vz = (x0_s3 == '0) && (y0_s3 == '0);
		x4      = x0_s3;
		y4      = y0_s3;
		z4      = a_s3;
		if (ctx_s3.op == OP_ROTATE) begin
			// take out a quarter turn exactly
			if (a_s3 > HALFPI_Q30) begin
				x4 = -y0_s3;
				y4 = x0_s3;
				z4 = a_s3 - HALFPI_Q30;
			end else if (a_s3 < -HALFPI_Q30) begin
				x4 = y0_s3;
				y4 = -x0_s3;
				z4 = a_s3 + HALFPI_Q30;
			end
		end else begin
			z4 = '0;
			if (x0_s3 < 0) begin
				x4 = -x0_s3;
				y4 = -y0_s3;
				z4 = (y0_s3 >= 0) ? PI_Q30 : -PI_Q30;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ctx_s4 <= ctx4;
			x_s4   <= x4;
			y_s4   <= y4;
			z_s4   <= z4;
		end
	end

	// ---------------- CORDIC row ----------------
	assign cv[0]   = v_s4;
	assign cctx[0] = ctx_s4;
	assign cx[0]   = x_s4;
	assign cy[0]   = y_s4;
	assign cz[0]   = z_s4;

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
		v2dfp_cordic_cell #(.SHIFT(i)) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (adv),
			.v_in   (cv[i]),
			.ctx_in (cctx[i]),
			.x_in   (cx[i]),
			.y_in   (cy[i]),
			.z_in   (cz[i]),
			.v_q    (cv[i+1]),
			.ctx_q  (cctx[i+1]),
			.x_q    (cx[i+1]),
			.y_q    (cy[i+1]),
			.z_q    (cz[i+1])
		);
	end

	// ---------------- stage 5 ----------------
	always_comb begin
		ctx5 = cctx[CORDIC_STEPS];
		mg   = (SATW'(cx[CORDIC_STEPS]) + HALF_G) >>> GUARD;
		ang  = (SATW'(cz[CORDIC_STEPS]) + HALF_A) >>> ASH;
		if (ctx5.vz) begin
			mg  = '0;
			ang = '0;
		end
		mm  = mg[DW-1:0];
		pxm = ctx5.px[31] ? 32'(-ctx5.px) : 32'(ctx5.px);
		pym = ctx5.py[31] ? 32'(-ctx5.py) : 32'(ctx5.py);
		fm  = ctx5.f[31] ? 32'(-ctx5.f) : 32'(ctx5.f);
		dv5 = mm;
		s5x = '0;
		s5y = '0;
		case (ctx5.op)
			OP_ROTATE: begin
				s5x = sat32(mg);
				s5y = sat32((SATW'(cy[CORDIC_STEPS]) + HALF_G) >>> GUARD);
				ctx5.rx  = s5x.v;
				ctx5.ry  = s5y.v;
				ctx5.ovf = s5x.ov || s5y.ov;
			end
			OP_MAGNITUDE: begin
				s5x = sat32(mg);
				ctx5.rs  = s5x.v;
				ctx5.ovf = s5x.ov;
			end
			OP_ANGLE: begin
				s5x = sat32(ang);
				ctx5.rs  = s5x.v;
				ctx5.ovf = s5x.ov;
			end
			OP_NORMALIZE: begin
				ctx5.dz   = (mm == '0);
				ctx5.negx = ctx5.px[31];
				ctx5.negy = ctx5.py[31];
			end
			OP_DIVIDE: begin
				dv5       = DW'(fm);
				ctx5.dz   = (ctx5.f == '0);
				ctx5.negx = ctx5.px[31] ^ ctx5.f[31];
				ctx5.negy = ctx5.py[31] ^ ctx5.f[31];
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (adv) begin
			v_s5 <= cv[CORDIC_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ctx_s5  <= ctx5;
			accx_s5 <= {pxm, {FRAC_BITS{1'b0}}};
			accy_s5 <= {pym, {FRAC_BITS{1'b0}}};
			dv_s5   <= dv5;
		end
	end

	// ---------------- divider row ----------------
	assign dvv[0]  = v_s5;
	assign dctx[0] = ctx_s5;
	assign dax[0]  = accx_s5;
	assign day[0]  = accy_s5;
	assign drx[0]  = '0;
	assign dry[0]  = '0;
	assign ddv[0]  = dv_s5;

	for (genvar k = 0; k < QW; k++) begin : g_div
		v2dfp_div_cell #(.QW(QW)) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (adv),
			.v_in    (dvv[k]),
			.ctx_in  (dctx[k]),
			.accx_in (dax[k]),
			.accy_in (day[k]),
			.remx_in (drx[k]),
			.remy_in (dry[k]),
			.dv_in   (ddv[k]),
			.v_q     (dvv[k+1]),
			.ctx_q   (dctx[k+1]),
			.accx_q  (dax[k+1]),
			.accy_q  (day[k+1]),
			.remx_q  (drx[k+1]),
			.remy_q  (dry[k+1]),
			.dv_q    (ddv[k+1])
		);
	end

	// ---------------- output register ----------------
	always_comb begin
		ctxf = dctx[QW];
		qvx  = SATW'(dax[QW]);
		qvy  = SATW'(day[QW]);
		if (ctxf.negx) qvx = -qvx;
		if (ctxf.negy) qvy = -qvy;
		sfx  = sat32(qvx);
		sfy  = sat32(qvy);
		fx   = ctxf.rx;
		fy   = ctxf.ry;
		fov  = ctxf.ovf;
		case (ctxf.op)
			OP_DIVIDE, OP_NORMALIZE: begin
				if (ctxf.dz) begin
					fx = ctxf.px;
					fy = ctxf.py;
				end else begin
					fx  = sfx.v;
					fy  = sfy.v;
					fov = sfx.ov || sfy.ov;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= dvv[QW];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_x_q        <= fx;
			res_y_q        <= fy;
			res_scalar_q   <= ctxf.rs;
			res_quadrant_q <= ctxf.rq;
			status_q       <= ctxf.dz ? ST_DIVZ : (fov ? ST_SAT : ST_OK);
		end
	end

	assign out_valid    = out_valid_q;
	assign res_x        = res_x_q;
	assign res_y        = res_y_q;
	assign res_scalar   = res_scalar_q;
	assign res_quadrant = res_quadrant_q;
	assign status       = status_q;

	// ---------------- assertions ----------------
	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (v_s1 && out_valid && !out_ready))
		else $error("input stalled while the pipeline could move");

	a_divz_passes_vector: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && dvv[QW] && dctx[QW].dz) |=>
		(status == ST_DIVZ && res_x == $past(dctx[QW].px) && res_y == $past(dctx[QW].py)))
		else $error("division by zero did not return the input vector");

	a_sat_has_limit: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == ST_SAT) |->
		(res_x == 32'sh7fff_ffff || res_x == 32'sh8000_0000 ||
		 res_y == 32'sh7fff_ffff || res_y == 32'sh8000_0000 ||
		 res_scalar == 32'sh7fff_ffff || res_scalar == 32'sh8000_0000))
		else $error("saturation status without a saturated value");

endmodule

// File: test/tb_vector2d_fixed_point_unit_core.sv
// Testbench for the 2-D fixed-point vector unit: directed and random items checked against a predictor.
module tb_vector2d_fixed_point_unit_core;
	import v2dfp_pkg::*;

	localparam int FRAC = 16;
	localparam int STEPS = 20;
	localparam int GB = 8;
	localparam longint KINV = 64'sd652032874;
	localparam longint PI30 = 64'sd3373259426;
	localparam longint HALFPI30 = 64'sd1686629713;
	localparam longint TWOPI30 = 64'sd6746518852;
	localparam int CYCLE_LIMIT = 600000;
	localparam int DRAIN_CYCLES = 200;

	typedef struct {
		logic signed [31:0] rx;
		logic signed [31:0] ry;
		logic signed [31:0] rs;
		logic [1:0]         rq;
		logic [1:0]         st;
	} vec_result_t;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic [3:0]         opcode;
	logic signed [31:0] px, py, qx, qy, factor;
	logic signed [18:0] turn_angle;
	logic               out_valid;
	logic               out_ready;
	logic signed [31:0] res_x, res_y, res_scalar;
	logic [1:0]         res_quadrant;
	logic [1:0]         status;

	vec_result_t pending_results[$];
	longint atan_tab[20];
	int errors;
	int cycles;
	bit idle_on;
	int stall_left;

	vector2d_fixed_point_unit_core i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.opcode(opcode), .px(px), .py(py), .qx(qx), .qy(qy),
		.factor(factor), .turn_angle(turn_angle),
		.out_valid(out_valid), .out_ready(out_ready),
		.res_x(res_x), .res_y(res_y), .res_scalar(res_scalar),
		.res_quadrant(res_quadrant), .status(status)
	);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	function automatic longint round_shift(longint v, int s);
		return (v + (64'sd1 <<< (s - 1))) >>> s;
	endfunction

	function automatic longint clip32(longint v, ref bit ov);
		if (v > 64'sd2147483647) begin
			ov = 1'b1;
			return 64'sd2147483647;
		end
		if (v < -64'sd2147483648) begin
			ov = 1'b1;
			return -64'sd2147483648;
		end
		return v;
	endfunction

	function automatic longint pre_gain(longint v);
		return round_shift(v * KINV, 30 - GB);
	endfunction

	function automatic void polar(longint x, longint y, output longint mag, output longint ang);
		longint z, nx, ny;
		z = 0;
		mag = 0;
		ang = 0;
		if (x == 0 && y == 0) return;
		if (x < 0) begin
			z = (y >= 0) ? PI30 : -PI30;
			x = -x;
			y = -y;
		end
		for (int i = 0; i < STEPS; i++) begin
			if (y > 0) begin
				nx = x + (y >>> i); ny = y - (x >>> i); z += atan_tab[i];
			end else begin
				nx = x - (y >>> i); ny = y + (x >>> i); z -= atan_tab[i];
			end
			x = nx;
			y = ny;
		end
		mag = x;
		ang = z;
	endfunction

	function automatic vec_result_t vector_op(logic [3:0] op, longint ax, longint ay,
			longint bx, longint by, longint f, longint ta);
		vec_result_t r;
		bit ov;
		longint x, y, m, a, nx, ny, h1, h2, l1, l2;
		ov = 1'b0;
		r.rx = 0; r.ry = 0; r.rs = 0; r.rq = Q_NE; r.st = ST_OK;
		case (op)
			OP_ADD: begin
				r.rx = clip32(ax + bx, ov); r.ry = clip32(ay + by, ov);
			end
			OP_SUB: begin
				r.rx = clip32(ax - bx, ov); r.ry = clip32(ay - by, ov);
			end
			OP_SCALE: begin
				r.rx = clip32(round_shift(ax * f, FRAC), ov);
				r.ry = clip32(round_shift(ay * f, FRAC), ov);
			end
			OP_DIVIDE: begin
				if (f == 0) begin
					r.rx = ax; r.ry = ay; r.st = ST_DIVZ;
				end else begin
					r.rx = clip32((ax <<< FRAC) / f, ov);
					r.ry = clip32((ay <<< FRAC) / f, ov);
				end
			end
			OP_NEGATE: begin
				r.rx = clip32(-ax, ov); r.ry = clip32(-ay, ov);
			end
			OP_ROTATE: begin
				a = ta <<< (30 - FRAC);
				if (a > PI30) a -= TWOPI30;
				if (a < -PI30) a += TWOPI30;
				x = pre_gain(ax);
				y = pre_gain(ay);
				if (a > HALFPI30) begin
					m = x; x = -y; y = m; a -= HALFPI30;
				end else if (a < -HALFPI30) begin
					m = x; x = y; y = -m; a += HALFPI30;
				end
				for (int i = 0; i < STEPS; i++) begin
					if (a >= 0) begin
						nx = x - (y >>> i); ny = y + (x >>> i); a -= atan_tab[i];
					end else begin
						nx = x + (y >>> i); ny = y - (x >>> i); a += atan_tab[i];
					end
					x = nx;
					y = ny;
				end
				r.rx = clip32(round_shift(x, GB), ov);
				r.ry = clip32(round_shift(y, GB), ov);
			end
			OP_NORMALIZE: begin
				polar(pre_gain(ax), pre_gain(ay), m, a);
				m = round_shift(m, GB);
				if (m == 0) begin
					r.rx = ax; r.ry = ay; r.st = ST_DIVZ;
				end else begin
					r.rx = clip32((ax <<< FRAC) / m, ov);
					r.ry = clip32((ay <<< FRAC) / m, ov);
				end
			end
			OP_QUADRANT: begin
				if (ax > 0 && ay >= 0) r.rq = Q_NE;
				else if (ax <= 0 && ay > 0) r.rq = Q_NW;
				else if (ax < 0 && ay <= 0) r.rq = Q_SW;
				else if (ax >= 0 && ay < 0) r.rq = Q_SE;
			end
			OP_MAGNITUDE: begin
				polar(pre_gain(ax), pre_gain(ay), m, a);
				r.rs = clip32(round_shift(m, GB), ov);
			end
			OP_ANGLE: begin
				polar(pre_gain(ax), pre_gain(ay), m, a);
				r.rs = clip32(round_shift(a, 30 - FRAC), ov);
			end
			OP_DOT: begin
				h1 = (ax * bx) >>> FRAC; l1 = ax * bx - (h1 <<< FRAC);
				h2 = (ay * by) >>> FRAC; l2 = ay * by - (h2 <<< FRAC);
				r.rs = clip32(h1 + h2 + round_shift(l1 + l2, FRAC), ov);
			end
			default: ;
		endcase
		if (r.st == ST_OK && ov) r.st = ST_SAT;
		return r;
	endfunction

	task automatic send_vector(logic [3:0] op, logic signed [31:0] ax, logic signed [31:0] ay,
			logic signed [31:0] bx, logic signed [31:0] by, logic signed [31:0] f,
			logic signed [18:0] ta);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
		in_valid <= 1'b1;
		opcode <= op; px <= ax; py <= ay; qx <= bx; qy <= by;
		factor <= f; turn_angle <= ta;
		do @(posedge clk); while (!in_ready);
		pending_results.push_back(vector_op(op, ax, ay, bx, by, f, ta));
	endtask

	function automatic logic signed [31:0] pick_coord();
		case ($urandom_range(0, 5))
			0: return $urandom;
			1: return $signed($urandom_range(0, 1 << 20)) - (1 << 19);
			2: return $signed($urandom_range(0, 8)) - 4;
			3: return $urandom_range(0, 1) ? 32'sh7fff_ffff : 32'sh8000_0000;
			default: return $signed($urandom_range(0, 1 << 26)) - (1 << 25);
		endcase
	endfunction

	function automatic logic signed [18:0] pick_turn();
		if ($urandom_range(0, 7) == 0) return $urandom;
		return $signed($urandom_range(0, 411774)) - 205887;
	endfunction

	task automatic run_random(int count);
		logic [3:0] op;
		for (int n = 0; n < count; n++) begin
			op = ($urandom_range(0, 19) == 0) ? $urandom_range(11, 15) : $urandom_range(0, 10);
			send_vector(op, pick_coord(), pick_coord(), pick_coord(), pick_coord(),
				($urandom_range(0, 15) == 0) ? 32'sd0 : pick_coord(), pick_turn());
		end
	endtask

	task automatic test_directed();
		send_vector(OP_ADD, 32'sh7fff_ffff, 32'sh8000_0000, 32'sd1, -32'sd1, 0, 0);
		send_vector(OP_SUB, 32'sh8000_0000, 32'sh7fff_ffff, 32'sd1, -32'sd1, 0, 0);
		send_vector(OP_SCALE, 32'sh7fff_ffff, -32'sd3, 0, 0, 32'sh8000_0000, 0);
		send_vector(OP_SCALE, 32'sd3, -32'sd3, 0, 0, 32'sd32768, 0);
		send_vector(OP_DIVIDE, 32'sd5, -32'sd7, 0, 0, 32'sd0, 0);
		send_vector(OP_DIVIDE, 32'sh7fff_ffff, 32'sh8000_0000, 0, 0, 32'sd1, 0);
		send_vector(OP_NEGATE, 32'sh8000_0000, 32'sh7fff_ffff, 0, 0, 0, 0);
		send_vector(OP_ROTATE, 32'sd65536, 32'sd0, 0, 0, 0, 19'sd205887);
		send_vector(OP_ROTATE, 32'sd65536, 32'sd65536, 0, 0, 0, 19'sh3ffff);
		send_vector(OP_ROTATE, 32'sh7fff_ffff, 32'sh8000_0000, 0, 0, 0, 19'sh40000);
		send_vector(OP_ROTATE, -32'sd65536, 32'sd100, 0, 0, 0, -19'sd150000);
		send_vector(OP_NORMALIZE, 32'sd0, 32'sd0, 0, 0, 0, 0);
		send_vector(OP_NORMALIZE, 32'sd1, 32'sd0, 0, 0, 0, 0);
		send_vector(OP_NORMALIZE, -32'sd300000, 32'sd400000, 0, 0, 0, 0);
		send_vector(OP_QUADRANT, 32'sd0, 32'sd0, 0, 0, 0, 0);
		send_vector(OP_QUADRANT, 32'sd0, 32'sd5, 0, 0, 0, 0);
		send_vector(OP_QUADRANT, -32'sd5, 32'sd0, 0, 0, 0, 0);
		send_vector(OP_QUADRANT, 32'sd0, -32'sd5, 0, 0, 0, 0);
		send_vector(OP_MAGNITUDE, 32'sh8000_0000, 32'sh8000_0000, 0, 0, 0, 0);
		send_vector(OP_ANGLE, 32'sd0, 32'sd0, 0, 0, 0, 0);
		send_vector(OP_ANGLE, -32'sd65536, 32'sd0, 0, 0, 0, 0);
		send_vector(OP_ANGLE, -32'sd65536, -32'sd1, 0, 0, 0, 0);
		send_vector(OP_DOT, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 0, 0);
		send_vector(4'd11, 32'sd1, 32'sd1, 32'sd1, 32'sd1, 32'sd1, 19'sd1);
		send_vector(4'd15, -32'sd1, -32'sd1, -32'sd1, -32'sd1, -32'sd1, -19'sd1);
	endtask

	task automatic test_random_with_idling();
		idle_on = 1'b1;
		run_random(900);
	endtask

	task automatic test_back_to_back();
		idle_on = 1'b0;
		run_random(150);
	endtask

	// receiver stalls in random bursts
	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_ready <= 1'b0;
		end else if (idle_on && $urandom_range(0, 5) == 0) begin
			stall_left <= $urandom_range(0, 9);
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		vec_result_t e;
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected transfer x=%0d y=%0d s=%0d q=%0d st=%0d",
					$time, res_x, res_y, res_scalar, res_quadrant, status);
				errors++;
			end else begin
				e = pending_results.pop_front();
				if (res_x !== e.rx || res_y !== e.ry || res_scalar !== e.rs ||
						res_quadrant !== e.rq || status !== e.st) begin
					$display("%0t: mismatch expected x=%0d y=%0d s=%0d q=%0d st=%0d",
						$time, e.rx, e.ry, e.rs, e.rq, e.st);
					$display("%0t:          actual   x=%0d y=%0d s=%0d q=%0d st=%0d",
						$time, res_x, res_y, res_scalar, res_quadrant, status);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		atan_tab = '{843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
			16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144, 131072,
			65536, 32768, 16384, 8192, 4096, 2048};
		errors = 0;
		cycles = 0;
		stall_left = 0;
		idle_on = 1'b1;
		arst_n = 1'b0;
		in_valid <= 1'b0;
		out_ready <= 1'b0;
		opcode <= 4'd0; px <= 0; py <= 0; qx <= 0; qy <= 0;
		factor <= 0; turn_angle <= 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random_with_idling();
		test_back_to_back();
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
